// ----- src/hcbd_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared constants, types and helpers for the Hill cipher block decryptor.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int LETTER_W       = 5;
  localparam int MODULUS        = 26;
  localparam int DATA_W         = 8;
  localparam int BLOCK_SIZE_DEF = 4;
  localparam int KEY_ROWS       = 4;
  localparam int KEY_W          = 20;
  localparam int KEY_IDX_W      = 2;

  // Dot product of one key row with a block: 4 * 25 * 25 = 2500 at most.
  localparam int ACC_W          = 12;
  // Quotient by 26 through a scaled reciprocal, exact for every dot-product sum (2500 at most).
  localparam int RECIP          = 2521;
  localparam int RECIP_SHIFT    = 16;
  localparam int PROD_W         = 24;
  localparam int Q_W            = 7;

  // Configuration register indexes
  localparam logic [KEY_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] REG_ROW3 = 2'd3;

  localparam logic [KEY_W-1:0] ROW0_RESET = 20'd1;
  localparam logic [KEY_W-1:0] ROW1_RESET = 20'd32;
  localparam logic [KEY_W-1:0] ROW2_RESET = 20'd1024;
  localparam logic [KEY_W-1:0] ROW3_RESET = 20'd32768;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [KEY_ROWS-1:0][KEY_W-1:0] key_rows_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Fold a 5-bit value into 0..25.
  function automatic letter_t reduce_letter(input letter_t v);
    return (v >= letter_t'(MODULUS)) ? v - letter_t'(MODULUS) : v;
  endfunction

endpackage

// ----- src/hcbd_front.sv -----
// ----------------------------------------------------------------------------
// hcbd_front
// Collects ciphertext letters and pushes each completed block to the queue.
// ----------------------------------------------------------------------------
module hcbd_front #(
  parameter int BLOCK_SIZE = hcbd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  hcbd_pkg::letter_t                          in_letter,
  input  hcbd_pkg::q_stat_t                          q_stat,
  output logic                                       push,
  output logic [BLOCK_SIZE*hcbd_pkg::LETTER_W-1:0]   push_block
);

  localparam int FILL_W = $clog2(BLOCK_SIZE);
  localparam int LW     = hcbd_pkg::LETTER_W;

  logic [FILL_W-1:0]    fill;
  hcbd_pkg::letter_t    held [BLOCK_SIZE-1];
  hcbd_pkg::letter_t    letter;
  logic                 accept;
  logic                 closing;

  assign letter   = hcbd_pkg::reduce_letter(in_letter);
  assign closing  = (fill == FILL_W'(BLOCK_SIZE - 1));
  // Letters that only fill the buffer never wait on the queue.
  assign in_ready = !closing || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && closing;

  always_comb begin
    for (int k = 0; k < BLOCK_SIZE - 1; k++) begin
      push_block[k*LW +: LW] = held[k];
    end
    push_block[(BLOCK_SIZE-1)*LW +: LW] = letter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= closing ? '0 : fill + FILL_W'(1);
    end
  end

  // Shift line: the first letter of a block ends up in held[0].
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < BLOCK_SIZE - 2; j++) begin
        held[j] <= held[j+1];
      end
      held[BLOCK_SIZE-2] <= letter;
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(BLOCK_SIZE - 1))
    else $error("fill count beyond block size");
`endif

endmodule

// ----- src/hcbd_queue.sv -----
// ----------------------------------------------------------------------------
// hcbd_queue
// Two-entry block queue between the letter collector and the row engine.
// ----------------------------------------------------------------------------
module hcbd_queue #(
  parameter int WIDTH = hcbd_pkg::BLOCK_SIZE_DEF * hcbd_pkg::LETTER_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output hcbd_pkg::q_stat_t stat
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into full block queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty block queue");
`endif

endmodule

// ----- src/hcbd_back.sv -----
// ----------------------------------------------------------------------------
// hcbd_back
// Row engine: a key row per unstalled cycle; dot product mod 26 in 3 stages.
// ----------------------------------------------------------------------------
module hcbd_back #(
  parameter int BLOCK_SIZE = hcbd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  hcbd_pkg::key_rows_t                      key_rows,
  input  hcbd_pkg::q_stat_t                        q_stat,
  input  logic [BLOCK_SIZE*hcbd_pkg::LETTER_W-1:0] head_block,
  output logic                                     pop,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output hcbd_pkg::letter_t                        out_letter,
  output logic                                     out_last
);

  localparam int ROW_W = $clog2(BLOCK_SIZE);
  localparam int LW    = hcbd_pkg::LETTER_W;
  localparam int AW    = hcbd_pkg::ACC_W;
  localparam int PW    = hcbd_pkg::PROD_W;

  logic [ROW_W-1:0]               row;
  logic                           row_last;
  logic                           advance;
  logic                           issue;
  logic [hcbd_pkg::KEY_W-1:0]     key_sel;
  hcbd_pkg::letter_t              entry;
  logic [AW-1:0]                  acc;
  logic [PW-1:0]                  prod;
  logic [AW-1:0]                  rem_wide;

  logic                           s1_valid;
  logic [AW-1:0]                  s1_acc;
  logic                           s1_last;
  logic                           s2_valid;
  logic [AW-1:0]                  s2_acc;
  logic [hcbd_pkg::Q_W-1:0]       s2_q;
  logic                           s2_last;

  assign row_last = (row == ROW_W'(BLOCK_SIZE - 1));
  assign advance  = !out_valid || out_ready;
  assign issue    = advance && !q_stat.empty;
  assign pop      = issue && row_last;

  // Stage 1: dot product of the selected key row with the head block.
  always_comb begin
    key_sel = key_rows[hcbd_pkg::KEY_IDX_W'(row)];
    acc     = '0;
    entry   = '0;
    for (int k = 0; k < BLOCK_SIZE; k++) begin
      entry = hcbd_pkg::reduce_letter(key_sel[k*LW +: LW]);
      acc   = acc + AW'(entry) * AW'(head_block[k*LW +: LW]);
    end
  end

  // Stage 2: quotient by 26 via reciprocal; stage 3: remainder.
  assign prod     = PW'(s1_acc) * PW'(hcbd_pkg::RECIP);
  assign rem_wide = s2_acc - AW'(s2_q) * AW'(hcbd_pkg::MODULUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        row <= row_last ? '0 : row + ROW_W'(1);
      end
      if (advance) begin
        s1_valid  <= issue;
        s2_valid  <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_acc     <= acc;
      s1_last    <= row_last;
      s2_acc     <= s1_acc;
      s2_q       <= prod[hcbd_pkg::RECIP_SHIFT +: hcbd_pkg::Q_W];
      s2_last    <= s1_last;
      out_letter <= rem_wide[LW-1:0];
      out_last   <= s2_last;
    end
  end

`ifndef SYNTH
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_letter < hcbd_pkg::letter_t'(hcbd_pkg::MODULUS)))
    else $error("plaintext letter out of range");
`endif

endmodule

// ----- src/hill_cipher_block_decrypt.sv -----
// ----------------------------------------------------------------------------
// hill_cipher_block_decrypt
// Streaming Hill cipher decryptor: BLOCK_SIZE ciphertext letters in, the
// same number of plaintext letters out, multiplied by the inverse key mod 26.
// ----------------------------------------------------------------------------
// Letters (A=0 .. Z=25) enter one per cycle on the s_ group while s_tready
// is high. The collector buffers the first BLOCK_SIZE-1 letters of a
// block; the last letter pushes the whole block into a two-entry queue.
// The row engine pops blocks and produces one plaintext letter per cycle
// (one key row each) unless m_tready stalls it, through a three-stage
// pipeline: dot product, reciprocal quotient, remainder. A block takes
// BLOCK_SIZE input and BLOCK_SIZE output letters, so the block sustains
// one letter per cycle on both sides when not stalled. With the row engine
// idle and the output not stalled, a block's final ciphertext letter goes
// into a queue slot and the first plaintext letter then passes the s1, s2
// and output registers. m_tlast marks the last letter of each block.
// The inverse key lives in four 20-bit rows written on the cfg_ port (entry
// k at bits 5k+4..5k, values above 25 folded mod 26); reset gives the
// identity. Write the key only while no block is in flight.
// ----------------------------------------------------------------------------
module hill_cipher_block_decrypt #(
  parameter int BLOCK_SIZE = hcbd_pkg::BLOCK_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Ciphertext stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hcbd_pkg::DATA_W-1:0]       s_tdata,   // [4:0] cipher_letter
  // Plaintext stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [hcbd_pkg::DATA_W-1:0]       m_tdata,   // [4:0] plain_letter
  output logic                              m_tlast,   // last_of_block
  // Key write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hcbd_pkg::KEY_IDX_W-1:0]    cfg_index,
  input  logic [hcbd_pkg::KEY_W-1:0]        cfg_data
);

  localparam int BLK_W = BLOCK_SIZE * hcbd_pkg::LETTER_W;

  hcbd_pkg::key_rows_t   key_rows;
  hcbd_pkg::q_stat_t     q_stat;
  logic                  push;
  logic [BLK_W-1:0]      push_block;
  logic                  pop;
  logic [BLK_W-1:0]      head_block;
  hcbd_pkg::letter_t     plain_letter;

  // Key rows: take a write every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows[0] <= hcbd_pkg::ROW0_RESET;
      key_rows[1] <= hcbd_pkg::ROW1_RESET;
      key_rows[2] <= hcbd_pkg::ROW2_RESET;
      key_rows[3] <= hcbd_pkg::ROW3_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hcbd_pkg::REG_ROW0: key_rows[0] <= cfg_data;
        hcbd_pkg::REG_ROW1: key_rows[1] <= cfg_data;
        hcbd_pkg::REG_ROW2: key_rows[2] <= cfg_data;
        hcbd_pkg::REG_ROW3: key_rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: collect letters, hand off whole blocks.
  hcbd_front #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_letter  (s_tdata[hcbd_pkg::LETTER_W-1:0]),
    .q_stat     (q_stat),
    .push       (push),
    .push_block (push_block)
  );

  // Queue: decouple collection from row processing.
  hcbd_queue #(
    .WIDTH(BLK_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_block),
    .pop       (pop),
    .pop_data  (head_block),
    .stat      (q_stat)
  );

  // Back: one plaintext letter per key row.
  hcbd_back #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .key_rows   (key_rows),
    .q_stat     (q_stat),
    .head_block (head_block),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_letter (plain_letter),
    .out_last   (m_tlast)
  );

  // Pad the letter up to a whole byte.
  assign m_tdata = {(hcbd_pkg::DATA_W - hcbd_pkg::LETTER_W)'(0), plain_letter};

endmodule
